FILE: sv/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gpe_pkg.sv
// Shared types, constants and Golay parity functions of the packet encoder.
package gpe_pkg;

  localparam int unsigned MaxPayloadDefault = 32;
  localparam int unsigned MaxResults        = 32;
  localparam int unsigned InfoBits          = 12;
  localparam int unsigned ParityBits        = 11;
  localparam int unsigned AddrBits          = 3;
  localparam int unsigned DataBits          = 32;

  localparam logic [11:0] GolayGen       = 12'hC75;
  localparam logic [7:0]  SyncResetValue = 8'h24;

  // Output kind codes.
  localparam logic [1:0] KindSync    = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindParity  = 2'd2;

  // Register indexes, decoded from the word address bit.
  localparam logic RegSyncFirst  = 1'b0;
  localparam logic RegSyncSecond = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       end_of_packet;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_byte_first;
    logic [7:0] sync_byte_second;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic emit_sync1;
    logic emit_sync2;
    logic emit_pay;
    logic drain;
    logic tail;
    logic rd_req;
    logic emit_par;
    logic emit_part;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_packet;
    logic room;
    logic last;
    logic buf_full;
    logic info_pending;
    logic rd_more;
    logic part_pending;
    logic out_free;
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SYNC1 = 10'b00_0000_0010,
    S_SYNC2 = 10'b00_0000_0100,
    S_PAY   = 10'b00_0000_1000,
    S_DRAIN = 10'b00_0001_0000,
    S_TAIL  = 10'b00_0010_0000,
    S_RDREQ = 10'b00_0100_0000,
    S_RDOUT = 10'b00_1000_0000,
    S_PART  = 10'b01_0000_0000,
    S_CLEAR = 10'b10_0000_0000
  } state_e;

  typedef logic [InfoBits-1:0][ParityBits-1:0] golay_rows_t;

  // Row i is the remainder of x^(11+i) divided by the generator.
  function automatic golay_rows_t golay_rows();
    golay_rows_t rows;
    logic [22:0] pat;
    for (int i = 0; i < InfoBits; i++) begin
      pat = 23'(1) << (ParityBits + i);
      for (int b = 22; b >= 11; b--) begin
        if (pat[b]) begin
          pat = pat ^ (23'(GolayGen) << (b - 11));
        end
      end
      rows[i] = pat[ParityBits-1:0];
    end
    return rows;
  endfunction

  localparam golay_rows_t GolayRows = golay_rows();

  // The remainder is linear in the word, so it is the XOR of one row per set bit.
  function automatic logic [ParityBits-1:0] golay_parity(input logic [InfoBits-1:0] word);
    logic [ParityBits-1:0] par;
    par = '0;
    for (int i = 0; i < InfoBits; i++) begin
      if (word[i]) begin
        par = par ^ GolayRows[i];
      end
    end
    return par;
  endfunction

endpackage

FILE: sv/gpe_cfg_regs.sv
// Configuration registers of the encoder behind an APB-style port.
module gpe_cfg_regs
  import gpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [7:0] sync_first_q;
  logic [7:0] sync_second_q;
  logic       wr_en;
  logic       reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrBits-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncResetValue;
      sync_second_q <= SyncResetValue;
    end else if (wr_en) begin
      case (reg_idx)
        RegSyncFirst:  sync_first_q  <= pwdata[7:0];
        RegSyncSecond: sync_second_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSyncFirst:  prdata = {{(DataBits-8){1'b0}}, sync_first_q};
      RegSyncSecond: prdata = {{(DataBits-8){1'b0}}, sync_second_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.sync_byte_first  = sync_first_q;
  assign cfg_o.sync_byte_second = sync_second_q;

endmodule

FILE: sv/gpe_ctrl.sv
// Sequencing state machine of the encoder: sync, payload, parity packing and flush.
`include "assert_macros.svh"

module gpe_ctrl
  import gpe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (!status_i.in_packet) begin
            state_d = S_SYNC1;
          end else if (status_i.room) begin
            state_d = S_PAY;
          end else begin
            state_d = S_DRAIN;
          end
        end
      end
      S_SYNC1: begin
        if (status_i.out_free) begin
          cmd_o.emit_sync1 = 1'b1;
          state_d          = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (status_i.out_free) begin
          cmd_o.emit_sync2 = 1'b1;
          state_d          = status_i.room ? S_PAY : S_DRAIN;
        end
      end
      S_PAY: begin
        if (status_i.out_free) begin
          cmd_o.emit_pay = 1'b1;
          state_d        = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.buf_full) begin
          cmd_o.drain = 1'b1;
        end else if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (status_i.info_pending) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_RDREQ;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_DRAIN;
      end
      S_RDREQ: begin
        if (status_i.rd_more) begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_RDOUT;
        end else if (status_i.part_pending) begin
          state_d = S_PART;
        end else begin
          state_d = S_CLEAR;
        end
      end
      S_RDOUT: begin
        if (status_i.out_free) begin
          cmd_o.emit_par = 1'b1;
          state_d        = S_RDREQ;
        end
      end
      S_PART: begin
        if (status_i.out_free) begin
          cmd_o.emit_part = 1'b1;
          state_d         = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  `ASSERT_IMPLIES(a_emit_needs_free_output,
    cmd_o.emit_sync1 || cmd_o.emit_sync2 || cmd_o.emit_pay || cmd_o.emit_par
      || cmd_o.emit_part,
    status_i.out_free, "result loaded while the output register is still occupied")

endmodule

FILE: sv/gpe_datapath.sv
// Datapath of the encoder: word assembly, parity packing, parity store and output register.
`include "assert_macros.svh"

module gpe_datapath
  import gpe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned WordsMax   = (MAX_PAYLOAD_BYTES * 8 + InfoBits - 1) / InfoBits;
  localparam int unsigned StoreDepth = (WordsMax * ParityBits + 7) / 8;
  localparam int unsigned StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned StoreCw    = $clog2(StoreDepth + 1);
  localparam int unsigned CountW     = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned ResW       = $clog2(MaxResults + 1);

  logic                   in_packet_q;
  logic                   overflow_q;
  logic [CountW-1:0]      payload_count_q;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic [InfoBits-1:0]    info_word_q;
  logic [3:0]             info_cnt_q;
  logic [18:0]            bitbuf_q;
  logic [4:0]             bufcnt_q;
  logic [StoreCw-1:0]     wr_idx_q;
  logic [StoreCw-1:0]     rd_idx_q;
  logic [ResW-1:0]        res_cnt_q;
  logic [7:0]             rd_data_q;
  logic                   out_valid_q;
  out_item_t              out_q;
  logic [7:0]             store_mem [StoreDepth];

  logic                   room;
  logic [19:0]            ext;
  logic [4:0]             total;
  logic [4:0]             sh;
  logic                   word_done;
  logic [InfoBits-1:0]    full_word;
  logic [InfoBits-1:0]    keep_mask;
  logic [InfoBits-1:0]    push_word;
  logic [ParityBits-1:0]  par_new;
  logic                   push;
  logic [7:0]             drain_byte;
  logic [7:0]             part_byte;
  logic                   emit;
  logic                   load;
  logic                   last_read;
  logic                   cap_last;
  out_item_t              out_d;

  assign room = payload_count_q < CountW'(MAX_PAYLOAD_BYTES);

  // Append the byte to the pending information bits; at most one word completes.
  assign ext       = {info_word_q, byte_q};
  assign total     = {1'b0, info_cnt_q} + 5'd8;
  assign word_done = total >= 5'd12;
  assign sh        = 5'(total - 5'd12);
  assign full_word = InfoBits'(ext >> sh[2:0]);
  assign keep_mask = (12'd1 << sh[2:0]) - 12'd1;

  // A short final word is right-aligned and then gets one zero appended.
  assign push_word = cmd_i.tail ? {info_word_q[InfoBits-2:0], 1'b0} : full_word;
  assign par_new   = golay_parity(push_word);
  assign push      = (cmd_i.emit_pay && word_done) || cmd_i.tail;

  assign drain_byte = 8'(bitbuf_q >> 5'(bufcnt_q - 5'd8));
  assign part_byte  = 8'({bitbuf_q[7:0], 8'h00} >> bufcnt_q[2:0]);

  assign emit = cmd_i.emit_sync1 | cmd_i.emit_sync2 | cmd_i.emit_pay | cmd_i.emit_par
              | cmd_i.emit_part;
  assign load = emit && (res_cnt_q < ResW'(MaxResults));

  assign last_read = (StoreCw'(rd_idx_q + StoreCw'(1)) == wr_idx_q) && (bufcnt_q == 5'd0);
  assign cap_last  = res_cnt_q == ResW'(MaxResults - 1);

  always_comb begin
    out_d.overflow      = overflow_q;
    out_d.end_of_packet = 1'b0;
    if (cmd_i.emit_sync1) begin
      out_d.out_byte = cfg_i.sync_byte_first;
      out_d.out_kind = KindSync;
    end else if (cmd_i.emit_sync2) begin
      out_d.out_byte = cfg_i.sync_byte_second;
      out_d.out_kind = KindSync;
    end else if (cmd_i.emit_pay) begin
      out_d.out_byte = byte_q;
      out_d.out_kind = KindPayload;
    end else if (cmd_i.emit_par) begin
      out_d.out_byte      = rd_data_q;
      out_d.out_kind      = KindParity;
      out_d.end_of_packet = last_read || cap_last;
    end else begin
      out_d.out_byte      = part_byte;
      out_d.out_kind      = KindParity;
      out_d.end_of_packet = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q     <= 1'b0;
      overflow_q      <= 1'b0;
      payload_count_q <= '0;
      info_word_q     <= '0;
      info_cnt_q      <= '0;
      bufcnt_q        <= '0;
      wr_idx_q        <= '0;
      rd_idx_q        <= '0;
      res_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        in_packet_q <= 1'b1;
        overflow_q  <= overflow_q | !room;
      end
      if (cmd_i.emit_pay) begin
        payload_count_q <= CountW'(payload_count_q + CountW'(1));
        info_word_q     <= word_done ? (ext[InfoBits-1:0] & keep_mask) : ext[InfoBits-1:0];
        info_cnt_q      <= word_done ? sh[3:0] : total[3:0];
      end
      if (cmd_i.tail) begin
        info_word_q <= '0;
        info_cnt_q  <= '0;
      end
      if (push) begin
        bufcnt_q <= 5'(bufcnt_q + 5'(ParityBits));
      end else if (cmd_i.drain) begin
        bufcnt_q <= 5'(bufcnt_q - 5'd8);
      end
      if (cmd_i.drain) begin
        wr_idx_q <= StoreCw'(wr_idx_q + StoreCw'(1));
      end
      if (cmd_i.emit_par) begin
        rd_idx_q <= StoreCw'(rd_idx_q + StoreCw'(1));
      end
      if (cmd_i.take) begin
        res_cnt_q <= '0;
      end else if (load) begin
        res_cnt_q <= ResW'(res_cnt_q + ResW'(1));
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        in_packet_q     <= 1'b0;
        overflow_q      <= 1'b0;
        payload_count_q <= '0;
        info_word_q     <= '0;
        info_cnt_q      <= '0;
        bufcnt_q        <= '0;
        wr_idx_q        <= '0;
        rd_idx_q        <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= in_data_i.payload_byte;
      last_q <= in_data_i.last_byte;
    end
    if (push) begin
      bitbuf_q <= {bitbuf_q[7:0], par_new};
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  // Parity store: one write port for packing, one registered read port for the flush.
  always_ff @(posedge clk_i) begin
    if (cmd_i.drain) begin
      store_mem[wr_idx_q[StoreAw-1:0]] <= drain_byte;
    end
    if (cmd_i.rd_req) begin
      rd_data_q <= store_mem[rd_idx_q[StoreAw-1:0]];
    end
  end

  assign status_o.in_packet    = in_packet_q;
  assign status_o.room         = room;
  assign status_o.last         = last_q;
  assign status_o.buf_full     = bufcnt_q >= 5'd8;
  assign status_o.info_pending = info_cnt_q != 4'd0;
  assign status_o.rd_more      = rd_idx_q < wr_idx_q;
  assign status_o.part_pending = bufcnt_q != 5'd0;
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLIES(a_push_into_drained_buffer, push, bufcnt_q <= 5'd7,
    "parity pushed before the bit buffer was drained")
  `ASSERT_IMPLIES(a_store_write_in_range, cmd_i.drain,
    wr_idx_q < StoreCw'(StoreDepth), "parity store write beyond its depth")
  `ASSERT_NEXT(a_clear_resets_packet, cmd_i.clear,
    !in_packet_q && (bufcnt_q == 5'd0) && (wr_idx_q == '0) && (info_cnt_q == 4'd0),
    "packet state not cleared after the flush")

endmodule

FILE: sv/golay_parity_packet_encoder.sv
// Top level of the Golay(23,12) parity packet encoder.
// The encoder takes one payload byte per input transaction. The first byte of a
// packet is preceded by the two programmable sync bytes, and every byte that fits
// within MAX_PAYLOAD_BYTES is forwarded unchanged as a payload result. Payload bits,
// MSB first, are collected into 12-bit words, and each word adds 11 Golay parity bits
// to an on-chip parity store. The transaction that carries last_byte closes the word
// in progress (a short word is right-aligned with one zero appended), then streams
// every stored parity byte and, if parity bits remain, a zero-padded final byte;
// end_of_packet marks the last parity byte. Bytes past the maximum are dropped and
// raise overflow on all later results of that packet. Input transactions are taken
// one at a time: a mid-packet payload byte is taken and emitted, then each parity byte
// that a completed word yields is written into the store (single write port); the
// first byte of a packet first emits the sync bytes. The last byte adds the flush:
// each stored parity byte is read through the registered read port and then emitted,
// and then the packet is closed. A stalled output holds back only the emitting steps:
// the output register holds a result while the next one is formed. The sync registers
// sit at byte addresses 0 and 4 and should be written while idle.
module golay_parity_packet_encoder
  import gpe_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // Output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Sync byte registers.
  gpe_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller walks each transaction through sync, payload, packing and flush.
  gpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds all packet state, the parity store and the output register.
  gpe_datapath #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/golay_packet_checker.sv
// Predicts the encoder's transmit bytes from the watched channels and compares them.
module golay_packet_checker
  import gpe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output int                  pending_o,
  output int                  mismatches_o
);

  localparam int unsigned WordsMax         = (MaxPayloadDefault * 8 + 11) / 12;
  localparam int unsigned ParityStoreBytes = (WordsMax * ParityBits + 7) / 8;

  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  logic        in_packet;
  int unsigned payload_count;
  logic [11:0] info_word;
  int unsigned info_bit_count;
  logic [7:0]  parity_store [ParityStoreBytes];
  int unsigned parity_bit_count;
  logic [7:0]  parity_partial;
  logic        overflow_seen;

  out_item_t   expected_tx_bytes [$];
  int          mismatch_count;

  function automatic logic [10:0] golay_check_bits(input logic [11:0] word);
    logic [22:0] rem;
    rem = {word, 11'b0};
    for (int b = 22; b >= 11; b--) begin
      if (rem[b]) begin
        rem = rem ^ ({11'b0, GolayGen} << (b - 11));
      end
    end
    return rem[10:0];
  endfunction

  task automatic reset_packet();
    in_packet        = 1'b0;
    payload_count    = 0;
    info_word        = '0;
    info_bit_count   = 0;
    parity_bit_count = 0;
    parity_partial   = '0;
    overflow_seen    = 1'b0;
    for (int i = 0; i < ParityStoreBytes; i++) begin
      parity_store[i] = '0;
    end
  endtask

  task automatic queue_result(input logic [7:0] b, input logic [1:0] kind, input logic eop);
    expected_tx_bytes.push_back('{out_byte: b, out_kind: kind, end_of_packet: eop,
                                  overflow: overflow_seen});
  endtask

  // Parity bits are packed MSB first; each completed byte goes to the store.
  task automatic append_parity(input logic [10:0] par);
    for (int i = 10; i >= 0; i--) begin
      parity_partial = {parity_partial[6:0], par[i]};
      parity_bit_count++;
      if (parity_bit_count % 8 == 0) begin
        parity_store[parity_bit_count / 8 - 1] = parity_partial;
        parity_partial = '0;
      end
    end
  endtask

  task automatic absorb_payload_byte(input in_item_t item);
    logic        accept;
    int unsigned full_bytes;
    int unsigned tail_bits;
    accept = (payload_count < MaxPayloadDefault);
    if (!accept) begin
      overflow_seen = 1'b1;
    end
    if (!in_packet) begin
      in_packet = 1'b1;
      queue_result(sync_first_q, KindSync, 1'b0);
      queue_result(sync_second_q, KindSync, 1'b0);
    end
    if (accept) begin
      payload_count++;
      queue_result(item.payload_byte, KindPayload, 1'b0);
      for (int i = 7; i >= 0; i--) begin
        info_word = {info_word[10:0], item.payload_byte[i]};
        info_bit_count++;
        if (info_bit_count == InfoBits) begin
          append_parity(golay_check_bits(info_word));
          info_word      = '0;
          info_bit_count = 0;
        end
      end
    end
    if (item.last_byte) begin
      // A short final word keeps its bits right-aligned with one zero appended.
      if (info_bit_count != 0) begin
        append_parity(golay_check_bits({info_word[10:0], 1'b0}));
        info_word      = '0;
        info_bit_count = 0;
      end
      full_bytes = parity_bit_count / 8;
      tail_bits  = parity_bit_count % 8;
      for (int k = 0; k < full_bytes; k++) begin
        queue_result(parity_store[k], KindParity, (tail_bits == 0) && (k == full_bytes - 1));
      end
      if (tail_bits != 0) begin
        queue_result(8'(parity_partial << (8 - tail_bits)), KindParity, 1'b1);
      end
      reset_packet();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_tx_bytes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected result: byte %h kind %0d eop %b ovf %b", got.out_byte,
                 got.out_kind, got.end_of_packet, got.overflow);
      end
    end else begin
      want = expected_tx_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.out_kind !== want.out_kind ||
          got.end_of_packet !== want.end_of_packet || got.overflow !== want.overflow) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected byte %h kind %0d eop %b ovf %b, got byte %h kind %0d eop %b ovf %b",
                   want.out_byte, want.out_kind, want.end_of_packet, want.overflow,
                   got.out_byte, got.out_kind, got.end_of_packet, got.overflow);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  = SyncResetValue;
      sync_second_q = SyncResetValue;
      reset_packet();
      expected_tx_bytes.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[AddrBits-1] == RegSyncSecond) begin
          sync_second_q = pwdata[7:0];
        end else begin
          sync_first_q = pwdata[7:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_payload_byte(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
    end
    pending_o    = expected_tx_bytes.size();
    mismatches_o = mismatch_count;
  end

endmodule

FILE: tb/golay_parity_packet_encoder_tb.sv
// Stimulus, clocking and verdict for the Golay parity packet encoder.
module golay_parity_packet_encoder_tb;
  import gpe_pkg::*;

  // Random part of the run and how it is cut into configuration phases.
  localparam int unsigned RandomItems  = 460;
  localparam int unsigned PhaseCount   = 6;
  // Cycles of quiet after the last expected result, so that a byte that gave no
  // result (a dropped one) and the packet close have surely finished.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 5_000_000;

  localparam logic [AddrBits-1:0] SyncFirstAddr  = {RegSyncFirst, 2'b00};
  localparam logic [AddrBits-1:0] SyncSecondAddr = {RegSyncSecond, 2'b00};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0] pwdata      = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  int                  results_outstanding;
  int                  mismatch_total;
  int unsigned         cycle_count = 0;
  int unsigned         items_sent  = 0;
  // While set, neither the sender nor the receiver inserts any idle cycles.
  logic                no_idling   = 1'b0;

  golay_parity_packet_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // The checker sees every transaction on both channels and every register
  // write, so it keeps its own copy of the sync bytes in step with the block.
  golay_packet_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending_o   (results_outstanding),
    .mismatches_o(mismatch_total)
  );

  always #2 clk_i = ~clk_i;

  // A hung handshake must not run forever: the run fails once the cycle budget
  // is used up, which is far beyond any correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Most idle stretches are short, a few are long enough to back up the block.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idling) begin
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Packet lengths lean short, but every length up to the maximum and a few
  // beyond it (which makes the block drop bytes) occur.
  function automatic int unsigned packet_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return $urandom_range(1, 6);
    end
    if (r < 75) begin
      return $urandom_range(7, 20);
    end
    if (r < 92) begin
      return $urandom_range(21, MaxPayloadDefault);
    end
    return $urandom_range(MaxPayloadDefault + 1, MaxPayloadDefault + 8);
  endfunction

  // Payload content is mostly random, with all-zero and all-one bytes mixed in.
  function automatic logic [7:0] payload_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver side: runs of ready cycles alternate with stall stretches.
  initial begin : out_stall_pattern
    int unsigned len;
    @(posedge clk_i);
    forever begin
      len = $urandom_range(1, 20);
      out_stall_i <= 1'b0;
      repeat (len) @(posedge clk_i);
      len = idle_length();
      if (len != 0) begin
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // One register write: a setup cycle, then an access cycle that completes at
  // the edge where pready is seen high. Upper data bits are random; only the
  // low byte lands in the register.
  task automatic write_sync_reg(input logic [AddrBits-1:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {DataBits'($urandom()) & ~DataBits'(8'hFF)} | DataBits'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one payload byte and holds it until the block takes the transaction.
  // A following gap lowers valid; with no gap, valid simply stays high.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= '{payload_byte: value, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    gap = idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_packet(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(payload_value(), i == len - 1);
    end
  endtask

  // The sender holds off until every predicted result has been delivered and
  // the block has had time to close the packet; register writes happen only here.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned first_len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed packets with the sync bytes still at their reset value.
    // A lone zero byte leaves a short final word of eight bits.
    send_byte(8'h00, 1'b1);
    // Three all-one bytes fill exactly two words, so no short word is closed,
    // and their 22 parity bits end in a zero-padded parity byte.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Twelve bytes make eight words, whose 88 parity bits fill whole bytes,
    // so the last stored byte carries the end of packet and nothing is padded.
    for (int unsigned i = 0; i < 12; i++) begin
      send_byte(8'(8'h81 + i * 8'h2D), i == 11);
    end
    wait_until_drained();

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      // Sync settings: both extremes crosswise, all ones, and random values.
      case (p)
        0: begin
          write_sync_reg(SyncFirstAddr, 8'h00);
          write_sync_reg(SyncSecondAddr, 8'hFF);
        end
        1: begin
          write_sync_reg(SyncFirstAddr, 8'hFF);
          write_sync_reg(SyncSecondAddr, 8'h00);
        end
        4: begin
          write_sync_reg(SyncFirstAddr, 8'hFF);
          write_sync_reg(SyncSecondAddr, 8'hFF);
        end
        default: begin
          write_sync_reg(SyncFirstAddr, 8'($urandom_range(0, 255)));
          write_sync_reg(SyncSecondAddr, 8'($urandom_range(0, 255)));
        end
      endcase
      // One phase runs back to back on both channels.
      no_idling = (p == 2);
      phase_end = 16 + (p + 1) * RandomItems / PhaseCount;
      // Some phases open with an over-long packet: with two extra bytes a
      // non-last byte is dropped before the dropped last byte; with one extra
      // byte only the last byte is dropped and still flushes the parity.
      if (p == 0 || p == 3) begin
        first_len = (p == 0) ? MaxPayloadDefault + 2 : MaxPayloadDefault + 1;
        send_packet(first_len);
      end
      while (items_sent < phase_end) begin
        send_packet(packet_length());
        if ($urandom_range(0, 19) == 0) begin
          wait_until_drained();
        end
      end
      wait_until_drained();
    end
    no_idling = 1'b0;

    if (mismatch_total == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/gpe_pkg.sv
sv/gpe_cfg_regs.sv
sv/gpe_ctrl.sv
sv/gpe_datapath.sv
sv/golay_parity_packet_encoder.sv
tb/golay_packet_checker.sv
tb/golay_parity_packet_encoder_tb.sv
